// ===== rtl/bcp_pkg.sv =====
package bcp_pkg;

  // Default build values of the top-level parameters
  localparam int MOTOR_LIMIT_DEF     = 7200;
  localparam int TURN_TARGET_MAX_DEF = 150;

  // Fixed control constants
  localparam int SPEED_CMD   = 10;
  localparam int STEER_STEP  = 30;
  localparam int TILT_BIAS   = 1856;  // 7.25 degree in 1/256 degree
  localparam int RECIP_25    = 335544; // floor(2^23 / 25)
  localparam int RECIP_SHIFT = 23;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPRIGHT_KP     = 3'd0,
    CFG_UPRIGHT_KD     = 3'd1,
    CFG_SPEED_KP       = 3'd2,
    CFG_YAW_KP         = 3'd3,
    CFG_YAW_KD         = 3'd4,
    CFG_FILTER_ALPHA   = 3'd5,
    CFG_BALANCE_OFFSET = 3'd6,
    CFG_INTEGRAL_LIMIT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [25:0]        upright_kp;
    logic [19:0]        upright_kd;
    logic [16:0]        speed_kp;
    logic [22:0]        yaw_kp;
    logic [19:0]        yaw_kd;
    logic [16:0]        filter_alpha;
    logic signed [12:0] balance_offset;
    logic [15:0]        integral_limit;
  } cfg_t;

  localparam logic [25:0]        UPRIGHT_KP_RST     = 26'd11796480;
  localparam logic [19:0]        UPRIGHT_KD_RST     = 20'd131072;
  localparam logic [16:0]        SPEED_KP_RST       = 17'd39322;
  localparam logic [22:0]        YAW_KP_RST         = 23'd655360;
  localparam logic [19:0]        YAW_KD_RST         = 20'd39322;
  localparam logic [16:0]        FILTER_ALPHA_RST   = 17'd45875;
  localparam logic signed [12:0] BALANCE_OFFSET_RST = 13'sd768;
  localparam logic [15:0]        INTEGRAL_LIMIT_RST = 16'd20000;

  // One input item and one result item
  typedef struct packed {
    logic signed [15:0] enc_left;
    logic signed [15:0] enc_right_raw;
    logic signed [16:0] roll_angle;
    logic signed [15:0] gyro_pitch;
    logic signed [15:0] gyro_yaw;
    logic               forward;
    logic               backward;
    logic               turn_left;
    logic               turn_right;
    logic               obstacle_near;
    logic               stop_request;
  } in_item_t;

  typedef struct packed {
    logic signed [13:0] motor_left;
    logic signed [13:0] motor_right;
    logic signed [31:0] upright_term;
    logic signed [15:0] speed_term;
    logic signed [31:0] steer_term;
  } out_item_t;

  // Microcode fields
  typedef enum logic [2:0] {
    A_OMA,
    A_ALPHA,
    A_SKP,
    A_RECIP,
    A_UKP,
    A_UKD,
    A_YKP,
    A_YKD
  } a_sel_e;

  typedef enum logic [2:0] {
    B_ERR,
    B_FE,
    B_TMP,
    B_Y,
    B_GP,
    B_ST,
    B_GY
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [3:0] {
    WR_NONE,
    WR_ERR,
    WR_FE,
    WR_SI,
    WR_TSUM,
    WR_Y,
    WR_Q,
    WR_SPD,
    WR_DIFF,
    WR_TMP5,
    WR_UPR,
    WR_ST,
    WR_STR,
    WR_OUT
  } wr_sel_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_IN,
    JMP_OUT,
    JMP_GOTO
  } jmp_e;

  localparam int UPROG_LEN = 21;
  localparam int PC_W      = $clog2(UPROG_LEN);

  typedef struct packed {
    a_sel_e          a_sel;
    b_sel_e          b_sel;
    acc_op_e         acc_op;
    wr_sel_e         wr_sel;
    jmp_e            jmp;
    logic [PC_W-1:0] tgt;
  } ucw_t;

  typedef struct packed {
    ucw_t cw;
    logic en;
  } ctrl_t;

endpackage

// ===== rtl/balance_cascade_pid_step_unit.sv =====
// Each item runs through the 21-step microprogram, which passes every multiply
// through one shared multiplier and accumulator; a new input is taken only
// after the previous item has run its last step.
// The next input is taken while a result still waits; the last step holds
// only if the previous result has not been taken yet.
// Reset (rst_ni low, asynchronous) clears loop state and restores the registers.
module balance_cascade_pid_step_unit #(
  parameter int MOTOR_LIMIT     = bcp_pkg::MOTOR_LIMIT_DEF,
  parameter int TURN_TARGET_MAX = bcp_pkg::TURN_TARGET_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [bcp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bcp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // enc_left[15:0], enc_right_raw[31:16], roll_angle[48:32],
  // gyro_pitch[64:49], gyro_yaw[80:65], zero[87:81]
  input  logic [87:0]                    s_axis_tdata,
  // forward[0], backward[1], turn_left[2], turn_right[3],
  // obstacle_near[4], stop_request[5]
  input  logic [5:0]                     s_axis_tuser,
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // motor_left[13:0], motor_right[27:14], upright_term[59:28],
  // speed_term[75:60], steer_term[107:76], zero[111:108]
  output logic [111:0]                   m_axis_tdata
);
  import bcp_pkg::*;

  cfg_t      cfg;
  ctrl_t     ctrl;
  in_item_t  item;
  out_item_t res;

  // Unpack the input transfer
  assign item.enc_left      = signed'(s_axis_tdata[15:0]);
  assign item.enc_right_raw = signed'(s_axis_tdata[31:16]);
  assign item.roll_angle    = signed'(s_axis_tdata[48:32]);
  assign item.gyro_pitch    = signed'(s_axis_tdata[64:49]);
  assign item.gyro_yaw      = signed'(s_axis_tdata[80:65]);
  assign item.forward       = s_axis_tuser[0];
  assign item.backward      = s_axis_tuser[1];
  assign item.turn_left     = s_axis_tuser[2];
  assign item.turn_right    = s_axis_tuser[3];
  assign item.obstacle_near = s_axis_tuser[4];
  assign item.stop_request  = s_axis_tuser[5];

  bcp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bcp_useq u_useq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .ctrl_o      (ctrl)
  );

  bcp_dpath #(
    .MOTOR_LIMIT     (MOTOR_LIMIT),
    .TURN_TARGET_MAX (TURN_TARGET_MAX)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .cfg_i  (cfg),
    .item_i (item),
    .res_o  (res)
  );

  // Pack the result transfer
  assign m_axis_tdata = {4'b0000, res.steer_term, res.speed_term, res.upright_term,
                         res.motor_right, res.motor_left};

endmodule

// ===== rtl/bcp_cfg_regs.sv =====
module bcp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bcp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bcp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output bcp_pkg::cfg_t                  cfg_o
);
  import bcp_pkg::*;

  cfg_t cfg_q;

  // Write the addressed register, keep the rest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upright_kp     <= UPRIGHT_KP_RST;
      cfg_q.upright_kd     <= UPRIGHT_KD_RST;
      cfg_q.speed_kp       <= SPEED_KP_RST;
      cfg_q.yaw_kp         <= YAW_KP_RST;
      cfg_q.yaw_kd         <= YAW_KD_RST;
      cfg_q.filter_alpha   <= FILTER_ALPHA_RST;
      cfg_q.balance_offset <= BALANCE_OFFSET_RST;
      cfg_q.integral_limit <= INTEGRAL_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_UPRIGHT_KP:     cfg_q.upright_kp     <= cfg_wdata_i[25:0];
        CFG_UPRIGHT_KD:     cfg_q.upright_kd     <= cfg_wdata_i[19:0];
        CFG_SPEED_KP:       cfg_q.speed_kp       <= cfg_wdata_i[16:0];
        CFG_YAW_KP:         cfg_q.yaw_kp         <= cfg_wdata_i[22:0];
        CFG_YAW_KD:         cfg_q.yaw_kd         <= cfg_wdata_i[19:0];
        CFG_FILTER_ALPHA:   cfg_q.filter_alpha   <= cfg_wdata_i[16:0];
        CFG_BALANCE_OFFSET: cfg_q.balance_offset <= signed'(cfg_wdata_i[12:0]);
        CFG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bcp_useq.sv =====
module bcp_useq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output bcp_pkg::ctrl_t ctrl_o
);
  import bcp_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  logic            out_valid_q, out_valid_d;
  ucw_t            cw;
  logic            en;

  function automatic ucw_t mk(input a_sel_e a, input b_sel_e b, input acc_op_e op,
                              input wr_sel_e wr, input jmp_e j);
    ucw_t w;
    w.a_sel  = a;
    w.b_sel  = b;
    w.acc_op = op;
    w.wr_sel = wr;
    w.jmp    = j;
    w.tgt    = '0;
    return w;
  endfunction

  // Microprogram: one control word per step
  function automatic ucw_t urom(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = mk(A_OMA, B_ERR, ACC_HOLD, WR_NONE, JMP_GOTO);
    unique case (pc)
      PC_W'(0):  w = mk(A_OMA,   B_ERR, ACC_HOLD, WR_ERR,  JMP_IN);
      PC_W'(1):  w = mk(A_OMA,   B_ERR, ACC_LOAD, WR_NONE, JMP_NEXT);
      PC_W'(2):  w = mk(A_ALPHA, B_FE,  ACC_ADD,  WR_NONE, JMP_NEXT);
      PC_W'(3):  w = mk(A_OMA,   B_ERR, ACC_HOLD, WR_FE,   JMP_NEXT);
      PC_W'(4):  w = mk(A_OMA,   B_ERR, ACC_HOLD, WR_SI,   JMP_NEXT);
      PC_W'(5):  w = mk(A_OMA,   B_ERR, ACC_HOLD, WR_TSUM, JMP_NEXT);
      PC_W'(6):  w = mk(A_SKP,   B_TMP, ACC_LOAD, WR_NONE, JMP_NEXT);
      PC_W'(7):  w = mk(A_OMA,   B_ERR, ACC_HOLD, WR_Y,    JMP_NEXT);
      PC_W'(8):  w = mk(A_RECIP, B_Y,   ACC_LOAD, WR_NONE, JMP_NEXT);
      PC_W'(9):  w = mk(A_OMA,   B_ERR, ACC_HOLD, WR_Q,    JMP_NEXT);
      PC_W'(10): w = mk(A_OMA,   B_ERR, ACC_HOLD, WR_SPD,  JMP_NEXT);
      PC_W'(11): w = mk(A_OMA,   B_ERR, ACC_HOLD, WR_DIFF, JMP_NEXT);
      PC_W'(12): w = mk(A_OMA,   B_ERR, ACC_HOLD, WR_TMP5, JMP_NEXT);
      PC_W'(13): w = mk(A_UKP,   B_TMP, ACC_LOAD, WR_NONE, JMP_NEXT);
      PC_W'(14): w = mk(A_UKD,   B_GP,  ACC_ADD,  WR_NONE, JMP_NEXT);
      PC_W'(15): w = mk(A_OMA,   B_ERR, ACC_HOLD, WR_UPR,  JMP_NEXT);
      PC_W'(16): w = mk(A_OMA,   B_ERR, ACC_HOLD, WR_ST,   JMP_NEXT);
      PC_W'(17): w = mk(A_YKP,   B_ST,  ACC_LOAD, WR_NONE, JMP_NEXT);
      PC_W'(18): w = mk(A_YKD,   B_GY,  ACC_ADD,  WR_NONE, JMP_NEXT);
      PC_W'(19): w = mk(A_OMA,   B_ERR, ACC_HOLD, WR_STR,  JMP_NEXT);
      PC_W'(20): w = mk(A_OMA,   B_ERR, ACC_HOLD, WR_OUT,  JMP_OUT);
      default:   w = mk(A_OMA,   B_ERR, ACC_HOLD, WR_NONE, JMP_GOTO);
    endcase
    return w;
  endfunction

  assign cw = urom(pc_q);

  // Step enable: wait on an input transfer or on a free output slot
  always_comb begin
    unique case (cw.jmp)
      JMP_IN:   en = in_valid_i;
      JMP_OUT:  en = !out_valid_q || out_ready_i;
      default:  en = 1'b1;
    endcase
  end

  // Next step
  always_comb begin
    pc_d = pc_q;
    if (en) begin
      unique case (cw.jmp)
        JMP_OUT, JMP_GOTO: pc_d = cw.tgt;
        default:           pc_d = pc_q + PC_W'(1);
      endcase
    end
  end

  // Output slot: fill on the last step, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cw.jmp == JMP_OUT && en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (cw.jmp == JMP_IN);
  assign out_valid_o = out_valid_q;
  assign ctrl_o.cw   = cw;
  assign ctrl_o.en   = en;

endmodule

// ===== rtl/bcp_dpath.sv =====
module bcp_dpath #(
  parameter int MOTOR_LIMIT     = bcp_pkg::MOTOR_LIMIT_DEF,
  parameter int TURN_TARGET_MAX = bcp_pkg::TURN_TARGET_MAX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bcp_pkg::ctrl_t     ctrl_i,
  input  bcp_pkg::cfg_t      cfg_i,
  input  bcp_pkg::in_item_t  item_i,
  output bcp_pkg::out_item_t res_o
);
  import bcp_pkg::*;

  localparam int STW = $clog2(TURN_TARGET_MAX + STEER_STEP + 1) + 1;
  localparam logic signed [STW-1:0] ST_MAX  = STW'(TURN_TARGET_MAX);
  localparam logic signed [STW-1:0] ST_STEP = STW'(STEER_STEP);
  localparam logic signed [32:0]    ML      = 33'(MOTOR_LIMIT);
  localparam logic signed [63:0]    FE_MAX  = 64'sd131071;
  localparam logic signed [63:0]    I32_MAX = 64'sd2147483647;
  localparam logic signed [63:0]    I32_MIN = -64'sd2147483648;

  // Latched item
  logic signed [17:0] err_q, err_d;
  logic signed [16:0] roll_q, roll_d;
  logic signed [15:0] gp_q, gp_d, gy_q, gy_d;
  logic               tl_q, tl_d, tr_q, tr_d, stop_q, stop_d;
  // Loop state
  logic signed [17:0]    fe_q, fe_d;
  logic signed [16:0]    si_q, si_d;
  logic signed [STW-1:0] st_q, st_d;
  // Scratch
  logic signed [63:0] acc_q, acc_d;
  logic signed [27:0] tmp_q, tmp_d;
  logic [22:0]        y_q, y_d;
  logic               neg_q, neg_d;
  logic [18:0]        q_q, q_d;
  logic signed [15:0] spd_q, spd_d;
  logic signed [25:0] diff_q, diff_d;
  logic signed [31:0] upr_q, upr_d, str_q, str_d;
  out_item_t          res_q, res_d;

  logic [16:0]        alpha_c, oma;
  logic signed [33:0] mul_a;
  logic signed [27:0] mul_b;
  logic signed [61:0] prod;

  // Divide by 2^sh, rounding toward zero
  function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] x,
                                                   input int unsigned sh);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    return (x + bias) >>> sh;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] c;
    c = (x > I32_MAX) ? I32_MAX : ((x < I32_MIN) ? I32_MIN : x);
    return c[31:0];
  endfunction

  function automatic logic signed [13:0] sat_motor(input logic signed [32:0] x);
    logic signed [32:0] c;
    c = (x > ML) ? ML : ((x < -ML) ? -ML : x);
    return c[13:0];
  endfunction

  // Filter weights, alpha capped at one
  assign alpha_c = (cfg_i.filter_alpha > 17'd65536) ? 17'd65536 : cfg_i.filter_alpha;
  assign oma     = 17'(18'd65536 - {1'b0, alpha_c});

  // Multiplier operand select
  always_comb begin
    unique case (ctrl_i.cw.a_sel)
      A_OMA:   mul_a = signed'(34'(oma));
      A_ALPHA: mul_a = signed'(34'(alpha_c));
      A_SKP:   mul_a = signed'(34'(cfg_i.speed_kp));
      A_RECIP: mul_a = 34'(RECIP_25);
      A_UKP:   mul_a = signed'(34'(cfg_i.upright_kp));
      A_UKD:   mul_a = signed'(34'({cfg_i.upright_kd, 10'd0}));
      A_YKP:   mul_a = signed'(34'(cfg_i.yaw_kp));
      A_YKD:   mul_a = (tl_q || tr_q) ? 34'sd0 : signed'(34'(cfg_i.yaw_kd));
      default: mul_a = 34'sd0;
    endcase
  end

  always_comb begin
    unique case (ctrl_i.cw.b_sel)
      B_ERR:   mul_b = 28'(err_q);
      B_FE:    mul_b = 28'(fe_q);
      B_TMP:   mul_b = tmp_q;
      B_Y:     mul_b = signed'(28'(y_q));
      B_GP:    mul_b = 28'(gp_q);
      B_ST:    mul_b = 28'(st_q);
      B_GY:    mul_b = 28'(gy_q);
      default: mul_b = 28'sd0;
    endcase
  end

  assign prod = mul_a * mul_b;

  // Accumulator
  always_comb begin
    unique case (ctrl_i.cw.acc_op)
      ACC_LOAD: acc_d = 64'(prod);
      ACC_ADD:  acc_d = acc_q + 64'(prod);
      default:  acc_d = acc_q;
    endcase
  end

  // Register write for the current step
  always_comb begin
    logic signed [17:0]    tgt;
    logic signed [63:0]    t;
    logic signed [18:0]    s19, lim19;
    logic signed [63:0]    mag;
    logic [18:0]           q0;
    logic [23:0]           r;
    logic signed [19:0]    sq;
    logic signed [STW-1:0] base, stn;
    logic signed [32:0]    sum_l, sum_r;

    err_d  = err_q;  roll_d = roll_q; gp_d = gp_q; gy_d = gy_q;
    tl_d   = tl_q;   tr_d   = tr_q;   stop_d = stop_q;
    fe_d   = fe_q;   si_d   = si_q;   st_d = st_q;
    tmp_d  = tmp_q;  y_d    = y_q;    neg_d = neg_q; q_d = q_q;
    spd_d  = spd_q;  diff_d = diff_q; upr_d = upr_q; str_d = str_q;
    res_d  = res_q;

    tgt   = 18'sd0;
    t     = 64'sd0;
    s19   = 19'sd0;
    lim19 = signed'({3'b000, cfg_i.integral_limit});
    mag   = 64'sd0;
    q0    = '0;
    r     = '0;
    sq    = 20'sd0;
    base  = '0;
    stn   = '0;
    sum_l = 33'sd0;
    sum_r = 33'sd0;

    unique case (ctrl_i.cw.wr_sel)
      WR_ERR: begin
        // Target speed: obstacle, then forward, then backward
        priority if (item_i.obstacle_near) tgt = -18'(SPEED_CMD);
        else if (item_i.forward)           tgt = 18'(SPEED_CMD);
        else if (item_i.backward)          tgt = -18'(SPEED_CMD);
        else                               tgt = 18'sd0;
        err_d  = 18'(item_i.enc_left) - 18'(item_i.enc_right_raw) - tgt;
        roll_d = item_i.roll_angle;
        gp_d   = item_i.gyro_pitch;
        gy_d   = item_i.gyro_yaw;
        tl_d   = item_i.turn_left;
        tr_d   = item_i.turn_right;
        stop_d = item_i.stop_request;
      end
      WR_FE: begin
        t    = trunc_shr(acc_q, 16);
        t    = (t > FE_MAX) ? FE_MAX : ((t < -FE_MAX) ? -FE_MAX : t);
        fe_d = t[17:0];
      end
      WR_SI: begin
        s19  = 19'(si_q) + 19'(fe_q);
        s19  = (s19 > lim19) ? lim19 : ((s19 < -lim19) ? -lim19 : s19);
        si_d = stop_q ? 17'sd0 : s19[16:0];
      end
      WR_TSUM: begin
        tmp_d = (28'(fe_q) <<< 7) + (28'(fe_q) <<< 6) + (28'(fe_q) <<< 3) + 28'(si_q);
      end
      WR_Y: begin
        // Magnitude over 2^19; the divide by 25 follows
        mag   = acc_q[63] ? -acc_q : acc_q;
        y_d   = mag[41:19];
        neg_d = acc_q[63];
      end
      WR_Q: begin
        // Reciprocal estimate is exact or one low
        q0  = acc_q[RECIP_SHIFT+18:RECIP_SHIFT];
        r   = 24'(y_q) - (24'(q0) << 4) - (24'(q0) << 3) - 24'(q0);
        q_d = (r >= 24'd25) ? q0 + 19'd1 : q0;
      end
      WR_SPD: begin
        sq    = neg_q ? -signed'(20'(q_q)) : signed'(20'(q_q));
        sq    = (sq > 20'sd32767) ? 20'sd32767 : ((sq < -20'sd32768) ? -20'sd32768 : sq);
        spd_d = sq[15:0];
      end
      WR_DIFF: begin
        diff_d = 26'(roll_q) + 26'(TILT_BIAS)
               - ((26'(spd_q) <<< 8) + 26'(cfg_i.balance_offset));
      end
      WR_TMP5: begin
        tmp_d = (28'(diff_q) <<< 2) + 28'(diff_q);
      end
      WR_UPR: begin
        upr_d = sat32(trunc_shr(acc_q, 26));
      end
      WR_ST: begin
        // Step the turn target; no turn input drops it to zero
        base = (tl_q || tr_q) ? st_q : '0;
        stn  = base - (tl_q ? ST_STEP : '0) + (tr_q ? ST_STEP : '0);
        st_d = (stn > ST_MAX) ? ST_MAX : ((stn < -ST_MAX) ? -ST_MAX : stn);
      end
      WR_STR: begin
        str_d = sat32(trunc_shr(acc_q, 16));
      end
      WR_OUT: begin
        sum_l = 33'(upr_q) - 33'(str_q);
        sum_r = 33'(upr_q) + 33'(str_q);
        res_d.motor_left   = sat_motor(sum_l);
        res_d.motor_right  = sat_motor(sum_r);
        res_d.upright_term = upr_q;
        res_d.speed_term   = spd_q;
        res_d.steer_term   = str_q;
      end
      default: ;
    endcase
  end

  // Loop state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_q <= '0;
      si_q <= '0;
      st_q <= '0;
    end else if (ctrl_i.en) begin
      fe_q <= fe_d;
      si_q <= si_d;
      st_q <= st_d;
    end
  end

  // Payload and scratch registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      err_q  <= err_d;
      roll_q <= roll_d;
      gp_q   <= gp_d;
      gy_q   <= gy_d;
      tl_q   <= tl_d;
      tr_q   <= tr_d;
      stop_q <= stop_d;
      acc_q  <= acc_d;
      tmp_q  <= tmp_d;
      y_q    <= y_d;
      neg_q  <= neg_d;
      q_q    <= q_d;
      spd_q  <= spd_d;
      diff_q <= diff_d;
      upr_q  <= upr_d;
      str_q  <= str_d;
      res_q  <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== sim/tb.sv =====
module tb;
  import bcp_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LAT_PAD     = 24;
  localparam int CHUNK_TICKS = 100;

  // Command flag masks, in tuser bit order
  localparam logic [5:0] CMD_NONE = 6'b000000;
  localparam logic [5:0] CMD_FWD  = 6'b000001;
  localparam logic [5:0] CMD_BWD  = 6'b000010;
  localparam logic [5:0] CMD_TL   = 6'b000100;
  localparam logic [5:0] CMD_TR   = 6'b001000;
  localparam logic [5:0] CMD_OBST = 6'b010000;
  localparam logic [5:0] CMD_STOP = 6'b100000;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // enc_left, enc_right_raw, roll_angle, gyro_pitch, gyro_yaw, zero pad
  logic [87:0]  s_axis_tdata  = '0;
  // forward, backward, turn_left, turn_right, obstacle_near, stop_request
  logic [5:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // motor_left, motor_right, upright_term, speed_term, steer_term, zero pad
  logic [111:0] m_axis_tdata;

  balance_cascade_pid_step_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Controller copy: gains and loop state
  cfg_t      ctl_regs;
  longint    fe_state;
  longint    integral_state;
  longint    steer_state;

  in_item_t  pending_ticks[$];
  out_item_t expected_cmds[$];
  in_item_t  tick_on_bus;
  in_item_t  next_tick;
  logic [4:0] held_cmds = '0;
  bit        no_idle = 1'b0;
  int        send_gap;
  int        stall_left;
  int        rx_pause;
  longint    cycle_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned motor_sat_cnt = 0;
  int unsigned clear_cnt = 0;

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Advance the controller by one tick and return the motor command it yields
  function automatic out_item_t control_tick(in_item_t t);
    longint    target, err, alpha, lim, spd, diff, upr, kd, str, ml, mr;
    out_item_t r;
    if (t.obstacle_near)  target = -SPEED_CMD;
    else if (t.forward)   target = SPEED_CMD;
    else if (t.backward)  target = -SPEED_CMD;
    else                  target = 0;
    err = longint'(t.enc_left) - longint'(t.enc_right_raw) - target;

    // Velocity PI: low-pass, integrate, clamp, clear on stop
    alpha = longint'(ctl_regs.filter_alpha);
    if (alpha > 65536) alpha = 65536;
    fe_state = ((65536 - alpha) * err + alpha * fe_state) / 65536;
    fe_state = sat(fe_state, -131071, 131071);
    lim = longint'(ctl_regs.integral_limit);
    integral_state = sat(integral_state + fe_state, -lim, lim);
    if (t.stop_request) begin
      integral_state = 0;
      clear_cnt++;
    end
    spd = (longint'(ctl_regs.speed_kp) * (200 * fe_state + integral_state)) / (65536 * 200);
    spd = sat(spd, -32768, 32767);

    // Upright PD around the shifted setpoint
    diff = longint'(t.roll_angle) + TILT_BIAS
         - (spd * 256 + longint'(ctl_regs.balance_offset));
    upr = (5 * longint'(ctl_regs.upright_kp) * diff
         + 1024 * longint'(ctl_regs.upright_kd) * longint'(t.gyro_pitch)) / 67108864;
    upr = sat(upr, -64'sd2147483648, 64'sd2147483647);

    // Turn PD: stepped target, damping only when no turn is held
    if (!t.turn_left && !t.turn_right) steer_state = 0;
    if (t.turn_left) steer_state -= STEER_STEP;
    if (t.turn_right) steer_state += STEER_STEP;
    steer_state = sat(steer_state, -TURN_TARGET_MAX_DEF, TURN_TARGET_MAX_DEF);
    kd = (!t.turn_left && !t.turn_right) ? longint'(ctl_regs.yaw_kd) : 0;
    str = (longint'(ctl_regs.yaw_kp) * steer_state + kd * longint'(t.gyro_yaw)) / 65536;
    str = sat(str, -64'sd2147483648, 64'sd2147483647);

    ml = sat(upr - str, -MOTOR_LIMIT_DEF, MOTOR_LIMIT_DEF);
    mr = sat(upr + str, -MOTOR_LIMIT_DEF, MOTOR_LIMIT_DEF);
    if (ml == MOTOR_LIMIT_DEF || ml == -MOTOR_LIMIT_DEF ||
        mr == MOTOR_LIMIT_DEF || mr == -MOTOR_LIMIT_DEF) motor_sat_cnt++;

    r.motor_left   = ml[13:0];
    r.motor_right  = mr[13:0];
    r.upright_term = upr[31:0];
    r.speed_term   = spd[15:0];
    r.steer_term   = str[31:0];
    return r;
  endfunction

  // Mostly short pauses, a few long ones, none while flow is forced
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(21, 60);
  endfunction

  function automatic int spread(int mag);
    return int'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  // Plausible driving ticks with held commands, plus raw noise
  function automatic in_item_t make_tick();
    in_item_t    t;
    logic [95:0] noise;
    int          mag;
    if ($urandom_range(0, 99) < 20) begin
      noise = {$urandom, $urandom, $urandom};
      t = noise[$bits(in_item_t)-1:0];
      return t;
    end
    for (int b = 0; b < 5; b++)
      if ($urandom_range(0, 7) == 0) held_cmds[b] = ~held_cmds[b];
    mag = ($urandom_range(0, 9) == 0) ? 4000 : 150;
    t.enc_left      = 16'(spread(mag));
    t.enc_right_raw = 16'(spread(mag));
    t.roll_angle    = 17'(spread(6000));
    t.gyro_pitch    = 16'(spread(4000));
    t.gyro_yaw      = 16'(spread(4000));
    t.forward       = held_cmds[0];
    t.backward      = held_cmds[1];
    t.turn_left     = held_cmds[2];
    t.turn_right    = held_cmds[3];
    t.obstacle_near = held_cmds[4];
    t.stop_request  = ($urandom_range(0, 29) == 0);
    return t;
  endfunction

  task automatic queue_tick(int el, int er, int roll, int gp, int gy, logic [5:0] cmd);
    in_item_t t;
    t.enc_left      = 16'(el);
    t.enc_right_raw = 16'(er);
    t.roll_angle    = 17'(roll);
    t.gyro_pitch    = 16'(gp);
    t.gyro_yaw      = 16'(gy);
    {t.stop_request, t.obstacle_near, t.turn_right,
     t.turn_left, t.backward, t.forward} = cmd;
    pending_ticks.push_back(t);
  endtask

  // Field extremes, several command mixes, turn target clamps and a stop
  task automatic queue_directed();
    queue_tick(0, 0, 0, 0, 0, CMD_NONE);
    queue_tick(32767, -32768, 65535, 32767, 32767, CMD_FWD);
    queue_tick(-32768, 32767, -65536, -32768, -32768, CMD_BWD);
    queue_tick(100, -100, 1000, 200, -300, CMD_FWD | CMD_BWD);
    queue_tick(50, 0, -500, 0, 0, CMD_OBST | CMD_FWD | CMD_BWD);
    repeat (6) queue_tick(5, -5, 300, 10, 400, CMD_TR);
    queue_tick(0, 0, 0, 0, 1000, CMD_TL | CMD_TR);
    repeat (11) queue_tick(-5, 5, -300, -10, -400, CMD_TL);
    queue_tick(200, -200, 0, 0, 0, CMD_STOP | CMD_FWD);
    queue_tick(0, 0, 0, 32767, -32768, CMD_NONE);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_UPRIGHT_KP:     ctl_regs.upright_kp     = val[25:0];
      CFG_UPRIGHT_KD:     ctl_regs.upright_kd     = val[19:0];
      CFG_SPEED_KP:       ctl_regs.speed_kp       = val[16:0];
      CFG_YAW_KP:         ctl_regs.yaw_kp         = val[22:0];
      CFG_YAW_KD:         ctl_regs.yaw_kd         = val[19:0];
      CFG_FILTER_ALPHA:   ctl_regs.filter_alpha   = val[16:0];
      CFG_BALANCE_OFFSET: ctl_regs.balance_offset = val[12:0];
      CFG_INTEGRAL_LIMIT: ctl_regs.integral_limit = val[15:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_gains(int ukp, int ukd, int skp, int ykp, int ykd,
                            int alpha, int ofs, int lim);
    write_reg(CFG_UPRIGHT_KP,     CFG_DATA_W'(ukp));
    write_reg(CFG_UPRIGHT_KD,     CFG_DATA_W'(ukd));
    write_reg(CFG_SPEED_KP,       CFG_DATA_W'(skp));
    write_reg(CFG_YAW_KP,         CFG_DATA_W'(ykp));
    write_reg(CFG_YAW_KD,         CFG_DATA_W'(ykd));
    write_reg(CFG_FILTER_ALPHA,   CFG_DATA_W'(alpha));
    write_reg(CFG_BALANCE_OFFSET, CFG_DATA_W'(ofs));
    write_reg(CFG_INTEGRAL_LIMIT, CFG_DATA_W'(lim));
  endtask

  // Hold until the block has returned every result, then let it settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ticks.size() != 0 || s_axis_tvalid || expected_cmds.size() != 0);
    repeat (LAT_PAD) @(posedge clk_i);
  endtask

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Sender: predict on each transfer, then launch the next tick after a gap
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_cmds.push_back(control_tick(tick_on_bus));
        ticks_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          next_tick     = pending_ticks.pop_front();
          tick_on_bus   <= next_tick;
          s_axis_tdata  <= {7'd0, next_tick.gyro_yaw, next_tick.gyro_pitch,
                            next_tick.roll_angle, next_tick.enc_right_raw,
                            next_tick.enc_left};
          s_axis_tuser  <= {next_tick.stop_request, next_tick.obstacle_near,
                            next_tick.turn_right, next_tick.turn_left,
                            next_tick.backward, next_tick.forward};
          s_axis_tvalid <= 1'b1;
          send_gap      <= idle_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each transfer with the oldest prediction, stall at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_cmds.size() == 0) begin
          $error("unexpected result transfer: %h", m_axis_tdata);
          mismatches++;
        end else begin
          out_item_t want;
          want = expected_cmds.pop_front();
          check_field("motor_left",   want.motor_left,   $signed(m_axis_tdata[13:0]));
          check_field("motor_right",  want.motor_right,  $signed(m_axis_tdata[27:14]));
          check_field("upright_term", want.upright_term, $signed(m_axis_tdata[59:28]));
          check_field("speed_term",   want.speed_term,   $signed(m_axis_tdata[75:60]));
          check_field("steer_term",   want.steer_term,   $signed(m_axis_tdata[107:76]));
        end
      end
      if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        rx_pause      = idle_len();
        stall_left    <= rx_pause;
        m_axis_tready <= (rx_pause == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    ctl_regs.upright_kp     = UPRIGHT_KP_RST;
    ctl_regs.upright_kd     = UPRIGHT_KD_RST;
    ctl_regs.speed_kp       = SPEED_KP_RST;
    ctl_regs.yaw_kp         = YAW_KP_RST;
    ctl_regs.yaw_kd         = YAW_KD_RST;
    ctl_regs.filter_alpha   = FILTER_ALPHA_RST;
    ctl_regs.balance_offset = BALANCE_OFFSET_RST;
    ctl_regs.integral_limit = INTEGRAL_LIMIT_RST;
    fe_state       = 0;
    integral_state = 0;
    steer_state    = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int setting = 0; setting < 6; setting++) begin
      // Setting 0 keeps the reset gains
      case (setting)
        1: load_gains(67108863, 1048575, 131071, 8388607, 1048575, 131071, -4096, 65535);
        2: load_gains(0, 0, 0, 0, 0, 0, 4095, 0);
        3: load_gains(65536000, 655360, 65536, 6553600, 655360, 65536, 2560, 65535);
        4: load_gains($urandom_range(0, 65536000), $urandom_range(0, 655360),
                      $urandom_range(0, 65536), $urandom_range(0, 6553600),
                      $urandom_range(0, 655360), $urandom_range(0, 65536),
                      -2560, $urandom_range(0, 500));
        5: load_gains($urandom_range(0, 65536000), $urandom_range(0, 655360),
                      $urandom_range(0, 65536), $urandom_range(0, 6553600),
                      $urandom_range(0, 655360), $urandom_range(0, 65536),
                      spread(2560), $urandom_range(0, 65535));
        default: ;
      endcase
      @(negedge clk_i);
      if (setting == 0 || setting == 1 || setting == 3) begin
        no_idle = 1'b0;
        queue_directed();
        wait_drained();
      end
      // Two random chunks, each drained before the next
      for (int chunk = 0; chunk < 2; chunk++) begin
        @(negedge clk_i);
        no_idle = (setting == 0 && chunk == 1) || ($urandom_range(0, 3) == 0);
        repeat (CHUNK_TICKS) pending_ticks.push_back(make_tick());
        wait_drained();
      end
    end

    $display("Ran %0d control ticks across six gain settings (reset, field maxima,",
             ticks_sent);
    $display("zeros, range maxima, two random); %0d results, %0d motor-saturated, %0d clears",
             results_seen, motor_sat_cnt, clear_cnt);
    if (mismatches == 0 && expected_cmds.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bcp_pkg.sv
rtl/bcp_cfg_regs.sv
rtl/bcp_useq.sv
rtl/bcp_dpath.sv
rtl/balance_cascade_pid_step_unit.sv
sim/tb.sv
